// File: src/ffca_pkg.sv
// ----------------------------------------------------------------------------
// ffca_pkg: shared definitions for the first-fit cell allocator
// Cell codes, word field widths and the default pool size.
// ----------------------------------------------------------------------------
`default_nettype none

package ffca_pkg;

  // default number of cells in the pool
  localparam int unsigned POOL_CELLS_DEF = 64;

  // cell map entry codes
  localparam int unsigned CELL_W = 2;
  localparam logic [CELL_W-1:0] CELL_FREE = 2'd0;
  localparam logic [CELL_W-1:0] CELL_USED = 2'd1;
  localparam logic [CELL_W-1:0] CELL_END  = 2'd2;

  // request kinds
  localparam logic ACT_ALLOC = 1'b0;
  localparam logic ACT_FREE  = 1'b1;

  // result status codes
  localparam logic STAT_OK   = 1'b0;
  localparam logic STAT_FAIL = 1'b1;

  // word field widths
  localparam int unsigned SIZE_W  = 7;
  localparam int unsigned START_W = 6;

endpackage

`default_nettype wire

// File: src/ffca_ram.sv
// ----------------------------------------------------------------------------
// ffca_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module ffca_ram #(
  parameter int unsigned WIDTH = 2,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// File: src/first_fit_cell_allocator.sv
// ----------------------------------------------------------------------------
// first_fit_cell_allocator: first-fit allocator over a pool of cells
// Allocates runs of free cells lowest-start first and frees them again.
// ----------------------------------------------------------------------------
// After reset the block sweeps the cell map to free, one cell per cycle, and
// s_tready stays low until the sweep ends. It then takes one request word at
// a time. The cell map lives in a RAM with one write and one registered read
// port, and each cycle of a walk handles one cell. An allocate scans from
// cell 0 up to the end of the first fitting run and writes that run one cell
// per cycle, or fails when the scan reaches the last cell; either way its
// result then goes through the result state to the output register. A free
// reads and clears from start_cell through the first end mark, or through the
// last cell if no end mark comes first, one cell per cycle. Zero size, oversize
// or an out-of-range free go from idle straight to the result state. A finished
// result sits in the output register and the next request is taken while it waits.
// ----------------------------------------------------------------------------
`default_nettype none

module first_fit_cell_allocator #(
  parameter int unsigned POOL_CELLS = ffca_pkg::POOL_CELLS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // request stream
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [15:0] s_tdata,  // [6:0] request_size, [12:7] start_cell, rest zero
  input  wire logic [0:0]  s_tuser,  // [0] action
  // result stream
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic      [7:0]  m_tdata,  // [5:0] block_start, rest zero
  output logic      [0:0]  m_tuser   // [0] status
);

  localparam int unsigned IDX_W = $clog2(POOL_CELLS);
  localparam int unsigned CNT_W = $clog2(POOL_CELLS + 1);
  localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(POOL_CELLS - 1);
  localparam logic [CNT_W-1:0] POOL_CNT  = CNT_W'(POOL_CELLS);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_MARK,
    ST_FREE,
    ST_RESULT
  } state_t;

  state_t state;

  // request fields
  logic                         in_action;
  logic [ffca_pkg::SIZE_W-1:0]  in_size;
  logic [ffca_pkg::START_W-1:0] in_start;

  // sequencer registers
  logic [CNT_W-1:0]            ptr;       // next cell to read or write
  logic                        rd_valid;  // read data belongs to a live read
  logic [IDX_W-1:0]            rd_idx;    // cell of the read data
  logic [ffca_pkg::SIZE_W-1:0] req_size;  // size of the request in progress
  logic [ffca_pkg::SIZE_W-1:0] run;       // free cells in current run
  logic [IDX_W-1:0]            first;     // start of current run
  logic [IDX_W-1:0]            end_idx;   // end cell of the run being marked
  logic                        res_status;
  logic [IDX_W-1:0]            res_start;

  // RAM ports
  logic                        we;
  logic [IDX_W-1:0]            waddr;
  logic [ffca_pkg::CELL_W-1:0] wdata;
  logic [ffca_pkg::CELL_W-1:0] rdata;

  // combinational helpers
  logic                        accept;
  logic                        issue;
  logic                        cell_free;
  logic [ffca_pkg::SIZE_W-1:0] run_next;
  logic [IDX_W-1:0]            first_next;
  logic                        hit;
  logic                        at_last;
  logic                        out_free;

  assign in_action = s_tuser[0];
  assign in_size   = s_tdata[6:0];
  assign in_start  = s_tdata[12:7];

  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;

  // read issue during scan and free walks
  assign issue = ((state == ST_SCAN) || (state == ST_FREE)) && (ptr < POOL_CNT);

  // one cell of first-fit evaluation
  always_comb begin
    cell_free  = (rdata == ffca_pkg::CELL_FREE);
    run_next   = cell_free ? (run + 1'b1) : '0;
    first_next = (cell_free && (run == '0)) ? rd_idx : first;
    hit        = rd_valid && cell_free && (run_next == req_size);
    at_last    = (rd_idx == LAST_IDX);
  end

  // RAM write port select
  always_comb begin
    we    = 1'b0;
    waddr = ptr[IDX_W-1:0];
    wdata = ffca_pkg::CELL_FREE;
    unique case (state)
      ST_CLEAR: begin
        we = 1'b1;
      end
      ST_MARK: begin
        we    = 1'b1;
        wdata = (ptr[IDX_W-1:0] == end_idx) ? ffca_pkg::CELL_END : ffca_pkg::CELL_USED;
      end
      ST_FREE: begin
        we    = rd_valid;
        waddr = rd_idx;
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  ffca_ram #(
    .WIDTH (ffca_pkg::CELL_W),
    .DEPTH (POOL_CELLS)
  ) u_map (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (ptr[IDX_W-1:0]),
    .rdata (rdata)
  );

  // sequencer and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      ptr      <= '0;
      rd_valid <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      rd_valid <= issue;
      if (issue) begin
        rd_idx <= ptr[IDX_W-1:0];
        ptr    <= ptr + 1'b1;
      end

      unique case (state)
        ST_CLEAR: begin
          ptr <= ptr + 1'b1;
          if (ptr[IDX_W-1:0] == LAST_IDX) begin
            state <= ST_IDLE;
          end
        end

        ST_IDLE: begin
          if (accept) begin
            res_status <= ffca_pkg::STAT_OK;
            res_start  <= '0;
            run        <= '0;
            first      <= '0;
            req_size   <= in_size;
            if (in_action == ffca_pkg::ACT_FREE) begin
              if (32'(in_start) < POOL_CELLS) begin
                ptr   <= CNT_W'(in_start);
                state <= ST_FREE;
              end else begin
                state <= ST_RESULT;
              end
            end else if ((in_size == '0) || (32'(in_size) > POOL_CELLS)) begin
              res_status <= ffca_pkg::STAT_FAIL;
              state      <= ST_RESULT;
            end else begin
              ptr   <= '0;
              state <= ST_SCAN;
            end
          end
        end

        ST_SCAN: begin
          if (rd_valid) begin
            run   <= run_next;
            first <= first_next;
            if (hit) begin
              // run found: mark it from its start
              rd_valid  <= 1'b0;
              end_idx   <= rd_idx;
              res_start <= first_next;
              ptr       <= CNT_W'(first_next);
              state     <= ST_MARK;
            end else if (at_last) begin
              rd_valid   <= 1'b0;
              res_status <= ffca_pkg::STAT_FAIL;
              state      <= ST_RESULT;
            end
          end
        end

        ST_MARK: begin
          ptr <= ptr + 1'b1;
          if (ptr[IDX_W-1:0] == end_idx) begin
            state <= ST_RESULT;
          end
        end

        ST_FREE: begin
          if (rd_valid && ((rdata == ffca_pkg::CELL_END) || at_last)) begin
            rd_valid <= 1'b0;
            state    <= ST_RESULT;
          end
        end

        ST_RESULT: begin
          if (out_free) begin
            m_tvalid <= 1'b1;
            m_tuser  <= res_status;
            m_tdata  <= {2'b00, ffca_pkg::START_W'(res_start)};
            state    <= ST_IDLE;
          end
        end

        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// File: tb/first_fit_cell_allocator_test.sv
// ----------------------------------------------------------------------------
// first_fit_cell_allocator_test: self-checking bench for the cell allocator
// Drives allocate and free request words with random source gaps and sink
// stalls, keeps a cell map of its own to predict each result word, and
// checks every result word field by field in arrival order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module first_fit_cell_allocator_test;

  localparam int unsigned POOL_CELLS = ffca_pkg::POOL_CELLS_DEF;
  localparam int unsigned RANDOM_WORDS = 400;
  localparam int unsigned CALM_WORDS = 60;

  typedef struct packed {
    logic                         status;
    logic [ffca_pkg::START_W-1:0] block_start;
  } alloc_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [15:0] s_tdata = '0;   // [6:0] request_size, [12:7] start_cell, rest zero
  logic [0:0]  s_tuser = '0;   // [0] action
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [7:0]  m_tdata;        // [5:0] block_start, rest zero
  logic [0:0]  m_tuser;        // [0] status

  // predicted cell map and results still owed by the block
  logic [ffca_pkg::CELL_W-1:0] cell_state [0:POOL_CELLS-1];
  alloc_result_t               pending_results[$];
  int                          error_count = 0;
  bit                          calm = 1'b0;   // no new source gaps or sink stalls when set
  int                          stall_left = 0;

  first_fit_cell_allocator #(
    .POOL_CELLS(POOL_CELLS)
  ) u_dut (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser)
  );

  // 2 ns clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // apply one request to the predicted cell map and return its result
  function automatic alloc_result_t apply_request(
      input logic act,
      input logic [ffca_pkg::SIZE_W-1:0] size,
      input logic [ffca_pkg::START_W-1:0] start);
    alloc_result_t res;
    int            run;
    int            first;
    bit            last;
    res.status      = ffca_pkg::STAT_OK;
    res.block_start = '0;
    run   = 0;
    first = 0;
    if (act == ffca_pkg::ACT_FREE) begin
      // clear through the first end mark or the pool end
      for (int k = start; k < POOL_CELLS; k++) begin
        last = (cell_state[k] == ffca_pkg::CELL_END);
        cell_state[k] = ffca_pkg::CELL_FREE;
        if (last) break;
      end
    end else begin
      res.status = ffca_pkg::STAT_FAIL;
      if (size != 0 && size <= POOL_CELLS) begin
        // lowest-starting run of free cells
        for (int k = 0; k < POOL_CELLS; k++) begin
          if (cell_state[k] != ffca_pkg::CELL_FREE) begin
            run = 0;
          end else begin
            if (run == 0) first = k;
            run++;
            if (run == size) begin
              for (int m = first; m < k; m++) cell_state[m] = ffca_pkg::CELL_USED;
              cell_state[k] = ffca_pkg::CELL_END;
              res.status      = ffca_pkg::STAT_OK;
              res.block_start = first[ffca_pkg::START_W-1:0];
              break;
            end
          end
        end
      end
    end
    return res;
  endfunction

  // send one request word; entered and left at a falling edge
  task automatic send_request(input logic act,
                              input logic [ffca_pkg::SIZE_W-1:0] size,
                              input logic [ffca_pkg::START_W-1:0] start,
                              output alloc_result_t res);
    bit accepted;
    accepted = 1'b0;
    if (!calm && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {3'b000, start, size};
    s_tuser  <= act;
    while (!accepted) begin
      @(posedge clk);
      accepted = s_tready;
    end
    res = apply_request(act, size, start);
    pending_results.push_back(res);
    @(negedge clk);
  endtask

  // sink side: random stall bursts, no new ones once calm
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      m_tready   <= 1'b0;
    end else if (!calm && $urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(0, 11);
      m_tready   <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  // result checker
  always @(posedge clk) begin
    alloc_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result word status=%0d block_start=%0d",
                 $time, m_tuser[0], m_tdata[ffca_pkg::START_W-1:0]);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        if (m_tuser[0] !== want.status) begin
          $display("%0t: status mismatch expected %0d actual %0d",
                   $time, want.status, m_tuser[0]);
          error_count++;
        end
        if (m_tdata[ffca_pkg::START_W-1:0] !== want.block_start) begin
          $display("%0t: block_start mismatch expected %0d actual %0d",
                   $time, want.block_start, m_tdata[ffca_pkg::START_W-1:0]);
          error_count++;
        end
      end
    end
  end

  // zero, oversize and whole-pool requests
  task automatic test_size_extremes();
    alloc_result_t res;
    send_request(ffca_pkg::ACT_ALLOC, 7'd0, 6'd0, res);
    send_request(ffca_pkg::ACT_ALLOC, 7'd127, 6'd63, res);
    send_request(ffca_pkg::ACT_ALLOC, 7'd65, 6'd0, res);
    send_request(ffca_pkg::ACT_ALLOC, 7'd64, 6'd0, res);
    send_request(ffca_pkg::ACT_ALLOC, 7'd1, 6'd0, res);   // pool full
    send_request(ffca_pkg::ACT_FREE, 7'd0, 6'd0, res);
  endtask

  // holes left by frees get reused lowest start first
  task automatic test_first_fit_holes();
    alloc_result_t res;
    send_request(ffca_pkg::ACT_ALLOC, 7'd4, 6'd0, res);
    send_request(ffca_pkg::ACT_ALLOC, 7'd4, 6'd0, res);
    send_request(ffca_pkg::ACT_ALLOC, 7'd4, 6'd0, res);
    send_request(ffca_pkg::ACT_FREE, 7'd0, 6'd4, res);
    send_request(ffca_pkg::ACT_ALLOC, 7'd2, 6'd0, res);
    send_request(ffca_pkg::ACT_ALLOC, 7'd3, 6'd0, res);   // skips the two-cell gap
    send_request(ffca_pkg::ACT_ALLOC, 7'd2, 6'd0, res);   // fills the gap
  endtask

  // frees of free cells, mid-block starts and blocks with no end mark
  task automatic test_partial_frees();
    alloc_result_t res;
    send_request(ffca_pkg::ACT_FREE, 7'd0, 6'd40, res);
    send_request(ffca_pkg::ACT_ALLOC, 7'd10, 6'd0, res);
    send_request(ffca_pkg::ACT_FREE, 7'd0, 6'd18, res);   // mid-block
    send_request(ffca_pkg::ACT_FREE, 7'd0, 6'd15, res);   // no end mark left, runs to pool end
    send_request(ffca_pkg::ACT_FREE, 7'd0, 6'd0, res);
    send_request(ffca_pkg::ACT_FREE, 7'd0, 6'd4, res);
    send_request(ffca_pkg::ACT_FREE, 7'd0, 6'd8, res);
    send_request(ffca_pkg::ACT_ALLOC, 7'd64, 6'd0, res);
    send_request(ffca_pkg::ACT_FREE, 7'd0, 6'd63, res);   // last cell only
    send_request(ffca_pkg::ACT_ALLOC, 7'd1, 6'd0, res);   // lowest free cell, cell 0
    send_request(ffca_pkg::ACT_FREE, 7'd0, 6'd0, res);
  endtask

  // mostly allocate/free of live blocks, some malformed requests
  task automatic test_random_traffic();
    alloc_result_t               res;
    int                          pick;
    int                          live_starts[$];
    logic [ffca_pkg::SIZE_W-1:0] size;
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      if (n == RANDOM_WORDS - CALM_WORDS) calm = 1'b1;
      live_starts.delete();
      for (int k = 0; k < POOL_CELLS; k++) begin
        if (cell_state[k] != ffca_pkg::CELL_FREE &&
            (k == 0 || cell_state[k-1] != ffca_pkg::CELL_USED))
          live_starts.push_back(k);
      end
      pick = $urandom_range(0, 99);
      if (pick >= 50 && pick < 85 && live_starts.size() != 0) begin
        pick = live_starts[$urandom_range(0, live_starts.size() - 1)];
        send_request(ffca_pkg::ACT_FREE, ffca_pkg::SIZE_W'($urandom),
                     ffca_pkg::START_W'(pick), res);
      end else if (pick >= 92) begin
        send_request(ffca_pkg::ACT_FREE, ffca_pkg::SIZE_W'($urandom),
                     ffca_pkg::START_W'($urandom), res);
      end else if (pick >= 85) begin
        send_request(ffca_pkg::ACT_ALLOC, ffca_pkg::SIZE_W'($urandom),
                     ffca_pkg::START_W'($urandom), res);
      end else begin
        pick = $urandom_range(0, 19);
        if (pick < 14) size = ffca_pkg::SIZE_W'($urandom_range(1, 8));
        else if (pick < 19) size = ffca_pkg::SIZE_W'($urandom_range(9, 32));
        else size = ffca_pkg::SIZE_W'($urandom_range(33, 64));
        send_request(ffca_pkg::ACT_ALLOC, size, ffca_pkg::START_W'($urandom), res);
      end
    end
  endtask

  // main sequence
  initial begin
    for (int k = 0; k < POOL_CELLS; k++) cell_state[k] = ffca_pkg::CELL_FREE;
    repeat (10) @(negedge clk);
    rst <= 1'b0;
    test_size_extremes();
    test_first_fit_holes();
    test_partial_frees();
    test_random_traffic();
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4 * POOL_CELLS) @(posedge clk);
    if (error_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2000000;
    $display("%0t: timeout with %0d results outstanding", $time, pending_results.size());
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

`default_nettype wire
